>>> rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int GRANULE_BYTES = 16;
    localparam int GRANULE_BITS  = 4;

    localparam int HEAP_BYTES_MAX_DEF  = 1048576;
    localparam int HEADER_BYTES_DEF    = 32;
    localparam int ALIGN_BYTES_DEF     = 16;
    localparam int MIN_SPLIT_BYTES_DEF = 16;

    localparam int ADDR_W      = 32;
    localparam int REQ_W       = 21;
    localparam int HEAP_CFG_W  = 21;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BYTES   = 1'd1;

    typedef struct packed {
        logic              command;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] free_address;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   payload_address;
    } rsp_t;

endpackage

>>> rtl/core/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
// first-fit heap allocator
// input channel: in_valid / in_stall with in_data carrying command, request_bytes and
// free_address; output channel: out_valid / out_stall with status and payload_address.
// one result transaction per input transaction, in order.
// headers live in a single-port-read, single-port-write table, one entry per 16-byte
// granule, with registered read data.
// allocate: a first-fit walk that reads one header per visit, plus a further write when a tail
// block is split off. free: reads the freed header, then its follower, if any, for the merge check.
// items are handled one at a time; a finished result sits in the output register, and
// the next item is taken while it waits for the receiver.
// when out_stall is high the result holds; the engine stalls only if a second result
// is ready before the first one was taken.
// after reset and after every configuration write the table is cleared over the heap
// range, then the initial free block is written if the heap can hold one; no
// item is taken during that pass, configuration writes still are.
// the user must write configuration only while the block is idle; the block does not enforce it.
module first_fit_heap_allocator_unit
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES_MAX  = HEAP_BYTES_MAX_DEF,
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES     = ALIGN_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = MIN_SPLIT_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  cmd_t                   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rsp_t                   out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int OW = $clog2(HEAP_BYTES_MAX);
    localparam int LW = OW + 1;
    localparam int IW = OW - GRANULE_BITS;
    localparam int SW = LW;
    localparam int EW = SW + 2;
    localparam int CW = ((LW > REQ_W + 1) ? LW : REQ_W + 1) + 3;
    localparam int HDR_SPAN = ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES)
                              * GRANULE_BYTES;
    localparam int RND = (ALIGN_BYTES > GRANULE_BYTES) ? ALIGN_BYTES : GRANULE_BYTES;
    localparam logic [CW-1:0] HDR_C   = CW'(HDR_SPAN);
    localparam logic [CW-1:0] SPLIT_C = CW'(HDR_SPAN + MIN_SPLIT_BYTES);
    localparam logic [CW-1:0] MINB_C  = CW'(HDR_SPAN + GRANULE_BYTES);
    localparam logic [CW-1:0] RND_M   = CW'(RND - 1);
    localparam logic [CW-1:0] CAP_C   = CW'(HEAP_BYTES_MAX);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_IDLE  = 4'd2;
    localparam logic [3:0] S_AWALK = 4'd3;
    localparam logic [3:0] S_AWRE  = 4'd4;
    localparam logic [3:0] S_FREAD = 4'd5;
    localparam logic [3:0] S_FNEXT = 4'd6;
    localparam logic [3:0] S_FWRE  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     base_reg;
    logic [HEAP_CFG_W-1:0] heap_reg;
    logic [IW:0]           clr_reg, clr_next;
    logic [CW-1:0]         off_reg, off_next;
    logic [CW-1:0]         req_reg, req_next;
    logic [CW-1:0]         esize_reg, esize_next;
    logic [CW-1:0]         noff_reg, noff_next;
    logic [STATUS_W-1:0]   st_reg, st_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic                  out_valid_reg;
    rsp_t                  out_data_reg;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_idx, rd_idx;
    logic [EW-1:0] wr_data, rd_data;

    logic [CW-1:0]     hb_raw, hb;
    logic [CW-1:0]     req_rnd;
    logic [ADDR_W-1:0] free_off;
    logic              e_valid, e_free;
    logic [CW-1:0]     e_size, e_next;
    logic [CW-1:0]     split_off;
    logic              out_free;

    ffa_hdr_mem #(
        .IW (IW),
        .EW (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign hb_raw   = CW'({heap_reg[HEAP_CFG_W-1:GRANULE_BITS], {GRANULE_BITS{1'b0}}});
    assign hb       = (hb_raw > CAP_C) ? CAP_C : hb_raw;
    assign req_rnd  = (CW'(in_data.request_bytes) + RND_M) & ~RND_M;
    assign free_off = in_data.free_address - base_reg - ADDR_W'(HDR_SPAN);
    assign e_valid  = rd_data[EW-1];
    assign e_free   = rd_data[EW-2];
    assign e_size   = CW'(rd_data[SW-1:0]);
    assign e_next   = off_reg + HDR_C + e_size;
    assign split_off = off_reg + HDR_C + req_reg;
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        off_next   = off_reg;
        req_next   = req_reg;
        esize_next = esize_reg;
        noff_next  = noff_reg;
        st_next    = st_reg;
        addr_next  = addr_reg;
        wr_en      = 1'b0;
        wr_idx     = '0;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_idx     = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == hb[IW+GRANULE_BITS:GRANULE_BITS])
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_idx   = clr_reg[IW-1:0];
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_INIT:
            begin
                if (hb >= MINB_C)
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, 1'b1, SW'(hb - HDR_C)};
                end
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next = '0;
                    if (in_data.command == CMD_ALLOC)
                    begin
                        req_next = req_rnd;
                        off_next = '0;
                        if (in_data.request_bytes == '0 || hb == '0)
                        begin
                            st_next    = ST_NO_FIT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_AWALK;
                        end
                    end
                    else if (in_data.free_address == '0)
                    begin
                        st_next    = ST_OK;
                        state_next = S_DONE;
                    end
                    else if (free_off >= ADDR_W'(hb) ||
                             free_off[GRANULE_BITS-1:0] != '0)
                    begin
                        st_next    = ST_BAD_FREE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        off_next   = CW'(free_off);
                        rd_en      = 1'b1;
                        rd_idx     = free_off[IW+GRANULE_BITS-1:GRANULE_BITS];
                        state_next = S_FREAD;
                    end
                end
            end
            S_AWALK:
            begin
                if (!e_valid)
                begin
                    st_next    = ST_NO_FIT;
                    state_next = S_DONE;
                end
                else if (e_free && e_size >= req_reg)
                begin
                    st_next   = ST_OK;
                    addr_next = base_reg + ADDR_W'(off_reg) + ADDR_W'(HDR_SPAN);
                    wr_en     = 1'b1;
                    if (e_size >= req_reg + SPLIT_C && split_off < hb)
                    begin
                        // carve the tail block first, then shrink the head
                        wr_idx     = split_off[IW+GRANULE_BITS-1:GRANULE_BITS];
                        wr_data    = {1'b1, 1'b1, SW'(e_size - req_reg - HDR_C)};
                        state_next = S_AWRE;
                    end
                    else
                    begin
                        wr_idx     = off_reg[IW+GRANULE_BITS-1:GRANULE_BITS];
                        wr_data    = {1'b1, 1'b0, SW'(e_size)};
                        state_next = S_DONE;
                    end
                end
                else if (e_next < hb)
                begin
                    off_next = e_next;
                    rd_en    = 1'b1;
                    rd_idx   = e_next[IW+GRANULE_BITS-1:GRANULE_BITS];
                end
                else
                begin
                    st_next    = ST_NO_FIT;
                    state_next = S_DONE;
                end
            end
            S_AWRE:
            begin
                wr_en      = 1'b1;
                wr_idx     = off_reg[IW+GRANULE_BITS-1:GRANULE_BITS];
                wr_data    = {1'b1, 1'b0, SW'(req_reg)};
                state_next = S_DONE;
            end
            S_FREAD:
            begin
                if (!e_valid)
                begin
                    st_next    = ST_BAD_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    st_next    = ST_OK;
                    esize_next = e_size;
                    if (e_next < hb)
                    begin
                        noff_next  = e_next;
                        rd_en      = 1'b1;
                        rd_idx     = e_next[IW+GRANULE_BITS-1:GRANULE_BITS];
                        state_next = S_FNEXT;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = off_reg[IW+GRANULE_BITS-1:GRANULE_BITS];
                        wr_data    = {1'b1, 1'b1, SW'(e_size)};
                        state_next = S_DONE;
                    end
                end
            end
            S_FNEXT:
            begin
                wr_en = 1'b1;
                if (e_valid && e_free)
                begin
                    // absorb the follower and drop its header
                    wr_idx     = noff_reg[IW+GRANULE_BITS-1:GRANULE_BITS];
                    wr_data    = '0;
                    esize_next = esize_reg + HDR_C + e_size;
                    state_next = S_FWRE;
                end
                else
                begin
                    wr_idx     = off_reg[IW+GRANULE_BITS-1:GRANULE_BITS];
                    wr_data    = {1'b1, 1'b1, SW'(esize_reg)};
                    state_next = S_DONE;
                end
            end
            S_FWRE:
            begin
                wr_en      = 1'b1;
                wr_idx     = off_reg[IW+GRANULE_BITS-1:GRANULE_BITS];
                wr_data    = {1'b1, 1'b1, SW'(esize_reg)};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = S_CLEAR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            base_reg      <= '0;
            heap_reg      <= HEAP_CFG_W'(HEAP_BYTES_MAX_DEF);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_ADDRESS: base_reg <= cfg_data;
                    REG_HEAP_BYTES:   heap_reg <= cfg_data[HEAP_CFG_W-1:0];
                    default:          base_reg <= base_reg;
                endcase
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg   <= off_next;
        req_reg   <= req_next;
        esize_reg <= esize_next;
        noff_reg  <= noff_next;
        st_reg    <= st_next;
        addr_reg  <= addr_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.status          <= st_reg;
            out_data_reg.payload_address <= addr_reg;
        end
    end

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> state_reg == S_CLEAR)
        else $error("configuration write did not restart the table clear");

    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.payload_address == '0)
        else $error("failed transaction carries an address");

    a_idle_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("header table written outside an operation");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid && out_stall && !cfg_we |=> state_reg == S_DONE)
        else $error("result left while previous one still stalled");

endmodule

>>> rtl/core/ffa_hdr_mem.sv
`timescale 1ns / 1ps

module ffa_hdr_mem
    import ffa_pkg::*;
#(
    parameter int IW = 16,
    parameter int EW = 23
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [EW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_idx,
    output logic [EW-1:0] rd_data
);

    logic [EW-1:0] mem [2**IW];
    logic [EW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
